/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the segment split block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* sv/bcs_pkg.sv */
// Package with widths, types and saturation for the cubic segment split.
package bcs_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int FRAC_WIDTH  = 16;
  // Control points and interpolated points need one bit more than a coordinate.
  localparam int PT_WIDTH    = COORD_WIDTH + 1;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 2;
  localparam int PROD_WIDTH  = DIFF_WIDTH + FRAC_WIDTH + 1;
  localparam int LATENCY     = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PT_WIDTH-1:0]    pt_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic        [FRAC_WIDTH-1:0]  frac_t;

  typedef struct packed {
    coord_t prev_out_new;
    coord_t next_in_new;
    coord_t mid_knot;
    coord_t mid_in;
    coord_t mid_out;
  } axis_res_t;

  localparam diff_t SAT_HI     = DIFF_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam diff_t SAT_LO     = -SAT_HI - DIFF_WIDTH'(1);
  localparam prod_t ROUND_HALF = PROD_WIDTH'(64'sd1 <<< (FRAC_WIDTH - 1));

  function automatic coord_t sat_coord(input diff_t v);
    coord_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/bcs_lerp.sv */
// One interpolation lane: multiply stage, then round and add stage.
module bcs_lerp (
  input  logic           clk,
  input  bcs_pkg::pt_t   a,
  input  bcs_pkg::pt_t   b,
  input  bcs_pkg::frac_t s,
  output bcs_pkg::pt_t   y
);

  bcs_pkg::diff_t                  diff;
  logic signed [bcs_pkg::FRAC_WIDTH:0] s_ext;
  bcs_pkg::prod_t                  prod_next;
  bcs_pkg::prod_t                  prod;
  bcs_pkg::pt_t                    a_q;
  bcs_pkg::prod_t                  rounded;
  bcs_pkg::diff_t                  step;

  always_comb begin
    diff      = bcs_pkg::DIFF_WIDTH'(b) - bcs_pkg::DIFF_WIDTH'(a);
    s_ext     = $signed({1'b0, s});
    prod_next = diff * s_ext;
  end

  // Round half up, then floor by an arithmetic shift.
  always_comb begin
    rounded = prod + bcs_pkg::ROUND_HALF;
    step    = bcs_pkg::DIFF_WIDTH'(rounded >>> bcs_pkg::FRAC_WIDTH);
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    a_q  <= a;
    y    <= bcs_pkg::PT_WIDTH'(bcs_pkg::DIFF_WIDTH'(a_q) + step);
  end

endmodule

/* sv/bcs_result.sv */
// Output stage of one axis: relative tangents and saturation to coordinate range.
module bcs_result (
  input  logic               clk,
  input  bcs_pkg::pt_t       pk,
  input  bcs_pkg::pt_t       nk,
  input  bcs_pkg::pt_t       b10,
  input  bcs_pkg::pt_t       b12,
  input  bcs_pkg::pt_t       b20,
  input  bcs_pkg::pt_t       b21,
  input  bcs_pkg::pt_t       b30,
  output bcs_pkg::axis_res_t res
);

  bcs_pkg::axis_res_t res_next;

  always_comb begin
    res_next.prev_out_new = bcs_pkg::sat_coord(bcs_pkg::DIFF_WIDTH'(b10)
                                               - bcs_pkg::DIFF_WIDTH'(pk));
    res_next.next_in_new  = bcs_pkg::sat_coord(bcs_pkg::DIFF_WIDTH'(b12)
                                               - bcs_pkg::DIFF_WIDTH'(nk));
    res_next.mid_knot     = bcs_pkg::sat_coord(bcs_pkg::DIFF_WIDTH'(b30));
    res_next.mid_in       = bcs_pkg::sat_coord(bcs_pkg::DIFF_WIDTH'(b20)
                                               - bcs_pkg::DIFF_WIDTH'(b30));
    res_next.mid_out      = bcs_pkg::sat_coord(bcs_pkg::DIFF_WIDTH'(b21)
                                               - bcs_pkg::DIFF_WIDTH'(b30));
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

/* sv/cubic_bezier_segment_split.sv */
// Top level of the cubic segment split: control points, three lerp levels, output stage.
//
// Usage: drive the two knots, their relative tangents and split_fraction, and
// raise start for one cycle per segment. A segment is taken at every rising
// edge with start high and busy low; busy is always low, so a new segment may
// be offered in every cycle.
// A result appears on the result ports with done high, for one cycle.
// Throughput: one segment per cycle. Stages: control point sums, then three
// interpolation levels of two stages each (multiply, then round and add), then
// relative tangents with saturation.
// Results leave in the order segments were taken. The receiver cannot hold a
// result off: it must take it in the cycle that done is high.
// Reset: rst clears the valid bits of every stage, so no result comes out for
// segments in flight at reset. The datapath registers are not reset.
`include "assert_macros.svh"

module cubic_bezier_segment_split (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bcs_pkg::coord_t  prev_knot_x,
  input  bcs_pkg::coord_t  prev_knot_y,
  input  bcs_pkg::coord_t  prev_out_x,
  input  bcs_pkg::coord_t  prev_out_y,
  input  bcs_pkg::coord_t  next_in_x,
  input  bcs_pkg::coord_t  next_in_y,
  input  bcs_pkg::coord_t  next_knot_x,
  input  bcs_pkg::coord_t  next_knot_y,
  input  bcs_pkg::frac_t   split_fraction,
  output logic             done,
  output bcs_pkg::coord_t  prev_out_new_x,
  output bcs_pkg::coord_t  prev_out_new_y,
  output bcs_pkg::coord_t  next_in_new_x,
  output bcs_pkg::coord_t  next_in_new_y,
  output bcs_pkg::coord_t  mid_knot_x,
  output bcs_pkg::coord_t  mid_knot_y,
  output bcs_pkg::coord_t  mid_in_x,
  output bcs_pkg::coord_t  mid_in_y,
  output bcs_pkg::coord_t  mid_out_x,
  output bcs_pkg::coord_t  mid_out_y
);

  logic [bcs_pkg::LATENCY-1:0] v_pipe;
  logic                        accept;

  bcs_pkg::coord_t pk_in [2];
  bcs_pkg::coord_t po_in [2];
  bcs_pkg::coord_t ni_in [2];
  bcs_pkg::coord_t nk_in [2];

  bcs_pkg::pt_t c1 [2];
  bcs_pkg::pt_t c2 [2];
  bcs_pkg::pt_t c3 [2];
  bcs_pkg::pt_t c4 [2];
  bcs_pkg::pt_t b10 [2];
  bcs_pkg::pt_t b11 [2];
  bcs_pkg::pt_t b12 [2];
  bcs_pkg::pt_t b20 [2];
  bcs_pkg::pt_t b21 [2];
  bcs_pkg::pt_t b30 [2];

  // Delay lines that line the knots and earlier levels up with the last level.
  bcs_pkg::pt_t pk_pipe  [2][6];
  bcs_pkg::pt_t nk_pipe  [2][6];
  bcs_pkg::pt_t b10_pipe [2][4];
  bcs_pkg::pt_t b12_pipe [2][4];
  bcs_pkg::pt_t b20_pipe [2][2];
  bcs_pkg::pt_t b21_pipe [2][2];

  bcs_pkg::frac_t s1;
  bcs_pkg::frac_t s2;
  bcs_pkg::frac_t s3;
  bcs_pkg::frac_t s4;
  bcs_pkg::frac_t s5;

  bcs_pkg::axis_res_t res [2];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pk_in[0] = prev_knot_x;
  assign pk_in[1] = prev_knot_y;
  assign po_in[0] = prev_out_x;
  assign po_in[1] = prev_out_y;
  assign ni_in[0] = next_in_x;
  assign ni_in[1] = next_in_y;
  assign nk_in[0] = next_knot_x;
  assign nk_in[1] = next_knot_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pipe <= '0;
    end else begin
      v_pipe <= {v_pipe[bcs_pkg::LATENCY-2:0], accept};
    end
  end

  assign done = v_pipe[bcs_pkg::LATENCY-1];

  // Fraction follows each interpolation level.
  always_ff @(posedge clk) begin
    s1 <= split_fraction;
    s2 <= s1;
    s3 <= s2;
    s4 <= s3;
    s5 <= s4;
  end

  for (genvar g = 0; g < 2; g++) begin : gen_axis
    always_ff @(posedge clk) begin
      c1[g] <= bcs_pkg::PT_WIDTH'(pk_in[g]);
      c2[g] <= bcs_pkg::PT_WIDTH'(pk_in[g]) + bcs_pkg::PT_WIDTH'(po_in[g]);
      c3[g] <= bcs_pkg::PT_WIDTH'(nk_in[g]) + bcs_pkg::PT_WIDTH'(ni_in[g]);
      c4[g] <= bcs_pkg::PT_WIDTH'(nk_in[g]);
    end

    always_ff @(posedge clk) begin
      pk_pipe[g][0]  <= c1[g];
      nk_pipe[g][0]  <= c4[g];
      b10_pipe[g][0] <= b10[g];
      b12_pipe[g][0] <= b12[g];
      b20_pipe[g][0] <= b20[g];
      b21_pipe[g][0] <= b21[g];
      for (int i = 1; i < 6; i++) begin
        pk_pipe[g][i] <= pk_pipe[g][i-1];
        nk_pipe[g][i] <= nk_pipe[g][i-1];
      end
      for (int i = 1; i < 4; i++) begin
        b10_pipe[g][i] <= b10_pipe[g][i-1];
        b12_pipe[g][i] <= b12_pipe[g][i-1];
      end
      b20_pipe[g][1] <= b20_pipe[g][0];
      b21_pipe[g][1] <= b21_pipe[g][0];
    end

    bcs_lerp u_l10 (.clk(clk), .a(c1[g]), .b(c2[g]), .s(s1), .y(b10[g]));
    bcs_lerp u_l11 (.clk(clk), .a(c2[g]), .b(c3[g]), .s(s1), .y(b11[g]));
    bcs_lerp u_l12 (.clk(clk), .a(c3[g]), .b(c4[g]), .s(s1), .y(b12[g]));
    bcs_lerp u_l20 (.clk(clk), .a(b10[g]), .b(b11[g]), .s(s3), .y(b20[g]));
    bcs_lerp u_l21 (.clk(clk), .a(b11[g]), .b(b12[g]), .s(s3), .y(b21[g]));
    bcs_lerp u_l30 (.clk(clk), .a(b20[g]), .b(b21[g]), .s(s5), .y(b30[g]));

    bcs_result u_res (
      .clk (clk),
      .pk  (pk_pipe[g][5]),
      .nk  (nk_pipe[g][5]),
      .b10 (b10_pipe[g][3]),
      .b12 (b12_pipe[g][3]),
      .b20 (b20_pipe[g][1]),
      .b21 (b21_pipe[g][1]),
      .b30 (b30[g]),
      .res (res[g])
    );
  end

  assign prev_out_new_x = res[0].prev_out_new;
  assign prev_out_new_y = res[1].prev_out_new;
  assign next_in_new_x  = res[0].next_in_new;
  assign next_in_new_y  = res[1].next_in_new;
  assign mid_knot_x     = res[0].mid_knot;
  assign mid_knot_y     = res[1].mid_knot;
  assign mid_in_x       = res[0].mid_in;
  assign mid_in_y       = res[1].mid_in;
  assign mid_out_x      = res[0].mid_out;
  assign mid_out_y      = res[1].mid_out;

  `ASSERT_CLK(a_first_stage_valid, clk, rst,
    !$past(rst) |-> (v_pipe[0] == $past(start && !busy)),
    "first stage valid does not follow the transfer")

  `ASSERT_NEVER(a_done_without_stage, clk, rst,
    done && !$past(v_pipe[bcs_pkg::LATENCY-2]),
    "done raised without an item in the last stage")

  `ASSERT_CLK(a_b10_between, clk, rst,
    v_pipe[2] |-> ((b10[0] >= $past(c1[0], 2) && b10[0] <= $past(c2[0], 2)) ||
                   (b10[0] <= $past(c1[0], 2) && b10[0] >= $past(c2[0], 2))),
    "first level point left the span of its control points")

  `ASSERT_CLK(a_b30_between, clk, rst,
    v_pipe[6] |-> ((b30[1] >= $past(b20[1], 2) && b30[1] <= $past(b21[1], 2)) ||
                   (b30[1] <= $past(b20[1], 2) && b30[1] >= $past(b21[1], 2))),
    "split point left the span of the second level points")

endmodule

/* tb/sv/testbench.sv */
// Testbench for the cubic segment split: random and directed segments checked against a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam bcs_pkg::coord_t CMAX = {1'b0, {(bcs_pkg::COORD_WIDTH-1){1'b1}}};
  localparam bcs_pkg::coord_t CMIN = {1'b1, {(bcs_pkg::COORD_WIDTH-1){1'b0}}};
  localparam int RANDOM_PER_PHASE = 360;

  typedef struct {
    bcs_pkg::coord_t pk_x, pk_y;
    bcs_pkg::coord_t po_x, po_y;
    bcs_pkg::coord_t ni_x, ni_y;
    bcs_pkg::coord_t nk_x, nk_y;
    bcs_pkg::frac_t  frac;
  } segment_t;

  typedef struct {
    bcs_pkg::axis_res_t x;
    bcs_pkg::axis_res_t y;
  } split_result_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  bcs_pkg::coord_t prev_knot_x = '0, prev_knot_y = '0;
  bcs_pkg::coord_t prev_out_x = '0, prev_out_y = '0;
  bcs_pkg::coord_t next_in_x = '0, next_in_y = '0;
  bcs_pkg::coord_t next_knot_x = '0, next_knot_y = '0;
  bcs_pkg::frac_t  split_fraction = '0;
  logic            busy, done;
  bcs_pkg::coord_t prev_out_new_x, prev_out_new_y, next_in_new_x, next_in_new_y;
  bcs_pkg::coord_t mid_knot_x, mid_knot_y, mid_in_x, mid_in_y, mid_out_x, mid_out_y;

  segment_t      pending_segments[$];
  split_result_t expected_splits[$];
  int            idle_pct = 0;
  int            mismatch_count = 0;

  cubic_bezier_segment_split u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .prev_knot_x(prev_knot_x), .prev_knot_y(prev_knot_y),
    .prev_out_x(prev_out_x), .prev_out_y(prev_out_y),
    .next_in_x(next_in_x), .next_in_y(next_in_y),
    .next_knot_x(next_knot_x), .next_knot_y(next_knot_y),
    .split_fraction(split_fraction), .done(done),
    .prev_out_new_x(prev_out_new_x), .prev_out_new_y(prev_out_new_y),
    .next_in_new_x(next_in_new_x), .next_in_new_y(next_in_new_y),
    .mid_knot_x(mid_knot_x), .mid_knot_y(mid_knot_y),
    .mid_in_x(mid_in_x), .mid_in_y(mid_in_y),
    .mid_out_x(mid_out_x), .mid_out_y(mid_out_y)
  );

  always #6 clk = ~clk;

  // Round half up: add half an LSB of the fraction, then floor.
  function automatic longint bez_lerp(longint a, longint b, longint s);
    longint p;
    p = (b - a) * s + (longint'(1) <<< (bcs_pkg::FRAC_WIDTH - 1));
    return a + (p >>> bcs_pkg::FRAC_WIDTH);
  endfunction

  function automatic bcs_pkg::coord_t clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (bcs_pkg::COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return bcs_pkg::coord_t'(v);
  endfunction

  function automatic bcs_pkg::axis_res_t split_one_axis(bcs_pkg::coord_t pk,
                                                        bcs_pkg::coord_t po,
                                                        bcs_pkg::coord_t ni,
                                                        bcs_pkg::coord_t nk,
                                                        bcs_pkg::frac_t frac);
    longint c1, c2, c3, c4, s, b10, b11, b12, b20, b21, b30;
    bcs_pkg::axis_res_t r;
    s   = longint'(frac);
    c1  = longint'(pk);
    c2  = longint'(pk) + longint'(po);
    c3  = longint'(nk) + longint'(ni);
    c4  = longint'(nk);
    b10 = bez_lerp(c1, c2, s);
    b11 = bez_lerp(c2, c3, s);
    b12 = bez_lerp(c3, c4, s);
    b20 = bez_lerp(b10, b11, s);
    b21 = bez_lerp(b11, b12, s);
    b30 = bez_lerp(b20, b21, s);
    r.prev_out_new = clamp_coord(b10 - c1);
    r.next_in_new  = clamp_coord(b12 - c4);
    r.mid_knot     = clamp_coord(b30);
    r.mid_in       = clamp_coord(b20 - b30);
    r.mid_out      = clamp_coord(b21 - b30);
    return r;
  endfunction

  function automatic split_result_t predict_split(segment_t g);
    split_result_t r;
    r.x = split_one_axis(g.pk_x, g.po_x, g.ni_x, g.nk_x, g.frac);
    r.y = split_one_axis(g.pk_y, g.po_y, g.ni_y, g.nk_y, g.frac);
    return r;
  endfunction

  // Corner patterns: flat, all max, all min, and knots against tangents.
  function automatic segment_t corner_segment(int pattern, bcs_pkg::frac_t frac);
    segment_t g;
    bcs_pkg::coord_t k0, t0, t1, k1;
    case (pattern)
      0: begin k0 = '0;   t0 = '0;   t1 = '0;   k1 = '0;   end
      1: begin k0 = CMAX; t0 = CMAX; t1 = CMAX; k1 = CMAX; end
      2: begin k0 = CMIN; t0 = CMIN; t1 = CMIN; k1 = CMIN; end
      3: begin k0 = CMIN; t0 = CMAX; t1 = CMAX; k1 = CMIN; end
      default: begin k0 = CMIN; t0 = CMAX; t1 = CMIN; k1 = CMAX; end
    endcase
    g.pk_x = k0; g.po_x = t0; g.ni_x = t1; g.nk_x = k1;
    // Mirror y so both signs meet in one segment.
    g.pk_y = ~k0; g.po_y = ~t0; g.ni_y = ~t1; g.nk_y = ~k1;
    g.frac = frac;
    return g;
  endfunction

  function automatic bcs_pkg::coord_t pick_coord(int mode);
    bcs_pkg::coord_t c;
    case (mode)
      0: c = bcs_pkg::coord_t'($urandom);
      1: c = bcs_pkg::coord_t'(int'($urandom_range(2000)) - 1000);
      default: begin
        case ($urandom_range(4))
          0: c = CMAX;
          1: c = CMIN;
          2: c = '0;
          3: c = '1;
          default: c = bcs_pkg::coord_t'($urandom);
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic segment_t random_segment();
    segment_t g;
    int sel, tan_mode;
    sel = $urandom_range(9);
    // Mostly full-range fields; some gentle curves and some extreme mixes.
    tan_mode = (sel < 6) ? 0 : (sel < 8) ? 1 : 2;
    g.pk_x = pick_coord(tan_mode == 1 ? 0 : tan_mode);
    g.pk_y = pick_coord(tan_mode == 1 ? 0 : tan_mode);
    g.nk_x = (tan_mode == 1) ? g.pk_x + pick_coord(1) : pick_coord(tan_mode);
    g.nk_y = (tan_mode == 1) ? g.pk_y + pick_coord(1) : pick_coord(tan_mode);
    g.po_x = pick_coord(tan_mode);
    g.po_y = pick_coord(tan_mode);
    g.ni_x = pick_coord(tan_mode);
    g.ni_y = pick_coord(tan_mode);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: g.frac = '0;
        1: g.frac = bcs_pkg::frac_t'(1);
        2: g.frac = bcs_pkg::frac_t'(1) << (bcs_pkg::FRAC_WIDTH - 1);
        default: g.frac = '1;
      endcase
    end else begin
      g.frac = bcs_pkg::frac_t'($urandom);
    end
    return g;
  endfunction

  task automatic check_field(string name, bcs_pkg::coord_t want, bcs_pkg::coord_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: hold an item until it is taken, then offer the next or idle.
  always @(posedge clk) begin
    segment_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pending_segments.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_segments.pop_front();
        prev_knot_x    <= nxt.pk_x;
        prev_knot_y    <= nxt.pk_y;
        prev_out_x     <= nxt.po_x;
        prev_out_y     <= nxt.po_y;
        next_in_x      <= nxt.ni_x;
        next_in_y      <= nxt.ni_y;
        next_knot_x    <= nxt.nk_x;
        next_knot_y    <= nxt.nk_y;
        split_fraction <= nxt.frac;
        start          <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: record each transfer in, then check each result against the oldest one.
  always @(posedge clk) begin
    segment_t      taken;
    split_result_t want, got;
    if (!rst) begin
      if (start && !busy) begin
        taken = '{prev_knot_x, prev_knot_y, prev_out_x, prev_out_y,
                  next_in_x, next_in_y, next_knot_x, next_knot_y, split_fraction};
        expected_splits.push_back(predict_split(taken));
      end
      if (done) begin
        if (expected_splits.size() == 0) begin
          $error("result with no segment outstanding");
          mismatch_count++;
        end else begin
          want = expected_splits.pop_front();
          got.x = '{prev_out_new_x, next_in_new_x, mid_knot_x, mid_in_x, mid_out_x};
          got.y = '{prev_out_new_y, next_in_new_y, mid_knot_y, mid_in_y, mid_out_y};
          check_field("prev_out_new_x", want.x.prev_out_new, got.x.prev_out_new);
          check_field("prev_out_new_y", want.y.prev_out_new, got.y.prev_out_new);
          check_field("next_in_new_x", want.x.next_in_new, got.x.next_in_new);
          check_field("next_in_new_y", want.y.next_in_new, got.y.next_in_new);
          check_field("mid_knot_x", want.x.mid_knot, got.x.mid_knot);
          check_field("mid_knot_y", want.y.mid_knot, got.y.mid_knot);
          check_field("mid_in_x", want.x.mid_in, got.x.mid_in);
          check_field("mid_in_y", want.y.mid_in, got.y.mid_in);
          check_field("mid_out_x", want.x.mid_out, got.x.mid_out);
          check_field("mid_out_y", want.y.mid_out, got.y.mid_out);
        end
      end
    end
  end

  task automatic drain_pipeline();
    while (pending_segments.size() != 0 || start || expected_splits.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    bcs_pkg::frac_t corner_fracs[4];
    int             phase_idle[3];
    corner_fracs = '{bcs_pkg::frac_t'(0), bcs_pkg::frac_t'(1),
                     bcs_pkg::frac_t'(1) << (bcs_pkg::FRAC_WIDTH - 1), '1};
    phase_idle   = '{23, 84, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int p = 0; p < 5; p++)
      foreach (corner_fracs[f])
        pending_segments.push_back(corner_segment(p, corner_fracs[f]));
    foreach (phase_idle[ph]) begin
      // Hold off new work until every outstanding split has come back.
      drain_pipeline();
      repeat (bcs_pkg::LATENCY + 2) @(negedge clk);
      idle_pct = phase_idle[ph];
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        pending_segments.push_back(random_segment());
    end
    drain_pipeline();
    repeat (bcs_pkg::LATENCY + 4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/bcs_pkg.sv
sv/bcs_lerp.sv
sv/bcs_result.sv
sv/cubic_bezier_segment_split.sv
tb/sv/testbench.sv
